// ===== sv/assert_macros.svh =====
// Assertion macros shared by the box-average downscaler RTL.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of aclk while out of reset.
`define BAVG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define BAVG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) pre |=> post) else $error(msg);

`endif

// ===== sv/bavg_pkg.sv =====
// Package for the box-average downscaler: field widths, register indexes,
// reset values and the flag group carried with each block sum. No dependencies.
`default_nettype none

package bavg_pkg;

    localparam int PIX_W = 8;
    localparam int MEAN_W = 8;
    localparam int SUM_W = 20;
    localparam int IMG_CFG_W = 11;
    localparam int BLK_CFG_W = 7;

    localparam int DEF_MAX_IMAGE_ROWS = 1024;
    localparam int DEF_MAX_IMAGE_COLS = 1024;
    localparam int DEF_MAX_BLOCK = 64;

    localparam logic [IMG_CFG_W-1:0] RST_IMAGE_ROWS = IMG_CFG_W'(100);
    localparam logic [IMG_CFG_W-1:0] RST_IMAGE_COLS = IMG_CFG_W'(100);
    localparam logic [BLK_CFG_W-1:0] RST_BLOCK_ROWS = BLK_CFG_W'(1);
    localparam logic [BLK_CFG_W-1:0] RST_BLOCK_COLS = BLK_CFG_W'(1);

    typedef enum logic [1:0] {
        REG_IMAGE_ROWS = 2'd0,
        REG_IMAGE_COLS = 2'd1,
        REG_BLOCK_ROWS = 2'd2,
        REG_BLOCK_COLS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } bavg_flags_t;

endpackage

`default_nettype wire

// ===== sv/bavg_divider.sv =====
// Restoring divider, one quotient bit per cycle, with the result register
// that drives the output stream. Depends on bavg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bavg_divider #(
    parameter int DIV_W = 13
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [bavg_pkg::SUM_W-1:0]     dividend,
    input  wire logic [DIV_W-1:0]               divisor,
    input  wire bavg_pkg::bavg_flags_t          flags_in,
    output logic                                ready,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bavg_pkg::MEAN_W-1:0]         m_tdata,  // mean_pixel
    output logic                                m_tlast,  // row_end
    output logic                                m_tuser   // frame_end
);
    import bavg_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        DV_IDLE = 3'b001,
        DV_RUN  = 3'b010,
        DV_DONE = 3'b100
    } dv_state_t;

    dv_state_t          state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    bavg_flags_t        flags_reg, flags_next;
    logic [DIV_W:0]     trial;

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        flags_next = flags_reg;
        trial = {rem_reg, quo_reg[SUM_W-1]};
        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    quo_next = dividend;
                    rem_next = '0;
                    div_next = divisor;
                    flags_next = flags_in;
                    step_next = '0;
                    state_next = DV_RUN;
                end
            end
            DV_RUN: begin
                if (trial >= {1'b0, div_reg}) begin
                    rem_next = DIV_W'(trial - {1'b0, div_reg});
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = DIV_W'(trial);
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = DV_DONE;
                end
            end
            DV_DONE: begin
                if (m_tready) begin
                    state_next = DV_IDLE;
                end
            end
            default: begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        step_reg <= step_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        flags_reg <= flags_next;
    end

    assign ready = (state_reg == DV_IDLE);
    assign m_tvalid = (state_reg == DV_DONE);
    assign m_tdata = quo_reg[MEAN_W-1:0];
    assign m_tlast = flags_reg.row_end;
    assign m_tuser = flags_reg.frame_end;

    `BAVG_ASSERT(a_step_range, (state_reg == DV_RUN) |-> (step_reg < STEP_W'(SUM_W)), "divider step count out of range")
    `BAVG_ASSERT(a_rem_bound, (state_reg == DV_DONE) |-> (rem_reg < div_reg), "divider remainder not below divisor")
    `BAVG_ASSERT_NEXT(a_start_runs, start && ready, state_reg == DV_RUN, "divider did not start on request")

endmodule

`default_nettype wire

// ===== sv/box_average_downscaler_top.sv =====
// Channel    Direction  Payload
// s_         in         tdata[7:0] pixel
// m_         out        tdata[7:0] mean_pixel, tlast row_end, tuser frame_end
// cfg_       in         cfg_index register number, cfg_data[10:0] value
//
// Each pixel goes through acceptance with the read of its column's
// accumulator, then the add and write back to that accumulator memory.
// A block's last pixel hands its sum to a serial divider; the
// write back waits while the divider is busy or its result is not taken.
// Reset is synchronous; the accumulator memory needs no clearing pass.
// Top level of the box-average downscaler. Depends on bavg_pkg,
// bavg_divider and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module box_average_downscaler_top #(
    parameter int MAX_IMAGE_ROWS = bavg_pkg::DEF_MAX_IMAGE_ROWS,
    parameter int MAX_IMAGE_COLS = bavg_pkg::DEF_MAX_IMAGE_COLS,
    parameter int MAX_BLOCK = bavg_pkg::DEF_MAX_BLOCK
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bavg_pkg::PIX_W-1:0]     s_tdata,   // pixel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bavg_pkg::MEAN_W-1:0]         m_tdata,   // mean_pixel
    output logic                                m_tlast,   // row_end
    output logic                                m_tuser,   // frame_end
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire bavg_pkg::cfg_reg_t             cfg_index,
    input  wire logic [bavg_pkg::IMG_CFG_W-1:0] cfg_data
);
    import bavg_pkg::*;

    localparam int RW = (MAX_IMAGE_ROWS > 1) ? $clog2(MAX_IMAGE_ROWS) : 1;
    localparam int CW = (MAX_IMAGE_COLS > 1) ? $clog2(MAX_IMAGE_COLS) : 1;
    localparam int BW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int DIV_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RMW  = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [IMG_CFG_W-1:0]   img_rows_reg, img_cols_reg;
    logic [BLK_CFG_W-1:0]   blk_rows_reg, blk_cols_reg;

    logic [RW-1:0]          row_reg, row_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [BW-1:0]          rib_reg, rib_next;
    logic [BW-1:0]          cib_reg, cib_next;
    logic [CW-1:0]          oc_reg, oc_next;

    logic [RW-1:0]          rows_m1;
    logic [CW-1:0]          cols_m1;
    logic [BW-1:0]          brows_m1, bcols_m1;
    logic                   last_col, last_row, blk_col_end, blk_row_end;
    logic [BW:0]            rib_p1, cib_p1;

    logic [SUM_W-1:0]       mem [MAX_IMAGE_COLS];
    logic [SUM_W-1:0]       rd_data_reg;
    logic [CW-1:0]          addr_reg;
    logic [PIX_W-1:0]       pix_reg;
    logic                   first_reg;
    logic                   blk_end_reg;
    bavg_flags_t            flags_reg;
    logic [DIV_W-1:0]       count_reg;
    logic [SUM_W-1:0]       wr_sum;

    logic                   accept;
    logic                   div_ready;
    logic                   proceed;
    logic                   div_start;

    // Configuration registers.
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_rows_reg <= RST_IMAGE_ROWS;
            img_cols_reg <= RST_IMAGE_COLS;
            blk_rows_reg <= RST_BLOCK_ROWS;
            blk_cols_reg <= RST_BLOCK_COLS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_IMAGE_ROWS: img_rows_reg <= cfg_data;
                REG_IMAGE_COLS: img_cols_reg <= cfg_data;
                REG_BLOCK_ROWS: blk_rows_reg <= cfg_data[BLK_CFG_W-1:0];
                REG_BLOCK_COLS: blk_cols_reg <= cfg_data[BLK_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sizes minus one, with zero read as one and large values saturated.
    always_comb begin
        priority if (img_rows_reg == '0) begin
            rows_m1 = '0;
        end else if (32'(img_rows_reg) > MAX_IMAGE_ROWS) begin
            rows_m1 = RW'(MAX_IMAGE_ROWS - 1);
        end else begin
            rows_m1 = RW'(img_rows_reg - 1'b1);
        end
        priority if (img_cols_reg == '0) begin
            cols_m1 = '0;
        end else if (32'(img_cols_reg) > MAX_IMAGE_COLS) begin
            cols_m1 = CW'(MAX_IMAGE_COLS - 1);
        end else begin
            cols_m1 = CW'(img_cols_reg - 1'b1);
        end
        priority if (blk_rows_reg == '0) begin
            brows_m1 = '0;
        end else if (32'(blk_rows_reg) > MAX_BLOCK) begin
            brows_m1 = BW'(MAX_BLOCK - 1);
        end else begin
            brows_m1 = BW'(blk_rows_reg - 1'b1);
        end
        priority if (blk_cols_reg == '0) begin
            bcols_m1 = '0;
        end else if (32'(blk_cols_reg) > MAX_BLOCK) begin
            bcols_m1 = BW'(MAX_BLOCK - 1);
        end else begin
            bcols_m1 = BW'(blk_cols_reg - 1'b1);
        end
    end

    assign last_col = (col_reg >= cols_m1);
    assign last_row = (row_reg >= rows_m1);
    assign blk_col_end = last_col || (cib_reg >= bcols_m1);
    assign blk_row_end = last_row || (rib_reg >= brows_m1);
    assign rib_p1 = (BW + 1)'(rib_reg) + 1'b1;
    assign cib_p1 = (BW + 1)'(cib_reg) + 1'b1;

    assign accept = s_tvalid && s_tready;
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign proceed = !blk_end_reg || div_ready;
    assign div_start = (state_reg == ST_RMW) && blk_end_reg && div_ready;

    // Raster position update, applied when a pixel is accepted.
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        rib_next = rib_reg;
        cib_next = cib_reg;
        oc_next = oc_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                cib_next = '0;
                oc_next = '0;
                if (last_row) begin
                    row_next = '0;
                    rib_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                    rib_next = blk_row_end ? '0 : rib_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
                if (blk_col_end) begin
                    cib_next = '0;
                    oc_next = oc_reg + 1'b1;
                end else begin
                    cib_next = cib_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW: begin
                if (proceed) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg <= '0;
            col_reg <= '0;
            rib_reg <= '0;
            cib_reg <= '0;
            oc_reg <= '0;
        end else begin
            state_reg <= state_next;
            row_reg <= row_next;
            col_reg <= col_next;
            rib_reg <= rib_next;
            cib_reg <= cib_next;
            oc_reg <= oc_next;
        end
    end

    // Per-transaction payload captured at acceptance.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= s_tdata;
            addr_reg <= oc_reg;
            first_reg <= (rib_reg == '0) && (cib_reg == '0);
            blk_end_reg <= blk_col_end && blk_row_end;
            flags_reg.row_end <= last_col;
            flags_reg.frame_end <= last_col && last_row;
            count_reg <= DIV_W'(rib_p1) * DIV_W'(cib_p1);
        end
    end

    assign wr_sum = first_reg ? SUM_W'(pix_reg) : rd_data_reg + SUM_W'(pix_reg);

    // Column accumulator memory: read on acceptance, written back from the update state once it may proceed.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_RMW) && proceed) begin
            mem[addr_reg] <= wr_sum;
        end
        if (accept) begin
            rd_data_reg <= mem[oc_reg];
        end
    end

    bavg_divider #(
        .DIV_W (DIV_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (wr_sum),
        .divisor  (count_reg),
        .flags_in (flags_reg),
        .ready    (div_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `BAVG_ASSERT_NEXT(a_accept_rmw, accept, state_reg == ST_RMW, "accepted pixel did not enter the update cycle")
    `BAVG_ASSERT(a_oc_le_col, 32'(oc_reg) <= 32'(col_reg), "output column ahead of pixel column")
    `BAVG_ASSERT_NEXT(a_stall_hold, (state_reg == ST_RMW) && !proceed, (state_reg == ST_RMW) && $stable(addr_reg), "stalled update lost its entry")

endmodule

`default_nettype wire

// ===== dv/bavg_mean_checker.sv =====
// Checker for the box-average downscaler: watches the pixel, mean and register channels,
// predicts every block mean and compares it with what the block delivers.
// Depends on bavg_pkg.
`timescale 1ns / 100ps

module bavg_mean_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bavg_pkg::PIX_W-1:0]     s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bavg_pkg::MEAN_W-1:0]    m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tuser,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  bavg_pkg::cfg_reg_t             cfg_index,
    input  logic [bavg_pkg::IMG_CFG_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             expected_left,
    output logic                           at_frame_start,
    output logic                           at_stripe_start,
    output logic                           at_block_start
);
    import bavg_pkg::*;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              row_end;
        logic              frame_end;
    } block_mean_t;

    block_mean_t mean_queue[$];

    logic [IMG_CFG_W-1:0] img_rows = RST_IMAGE_ROWS;
    logic [IMG_CFG_W-1:0] img_cols = RST_IMAGE_COLS;
    logic [BLK_CFG_W-1:0] blk_rows = RST_BLOCK_ROWS;
    logic [BLK_CFG_W-1:0] blk_cols = RST_BLOCK_COLS;

    logic [SUM_W-1:0] stripe_sums [DEF_MAX_IMAGE_COLS];
    logic [9:0]       row_pos = '0;
    logic [9:0]       col_pos = '0;
    logic [5:0]       row_in_blk = '0;
    logic [5:0]       col_in_blk = '0;
    logic [9:0]       out_col = '0;

    initial begin
        mismatches = 0;
        expected_left = 0;
    end

    assign at_block_start = (row_in_blk == '0) && (col_in_blk == '0);
    assign at_stripe_start = at_block_start && (col_pos == '0);
    assign at_frame_start = at_stripe_start && (row_pos == '0);

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned cap);
        if (v == 0) begin
            return 1;
        end
        return (v > cap) ? cap : v;
    endfunction

    task automatic accumulate_pixel(input logic [PIX_W-1:0] px);
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned brows_eff;
        int unsigned bcols_eff;
        int unsigned count;
        logic        last_col;
        logic        last_row;
        logic        col_done;
        logic        row_done;
        block_mean_t res;
        rows_eff = eff_size(img_rows, DEF_MAX_IMAGE_ROWS);
        cols_eff = eff_size(img_cols, DEF_MAX_IMAGE_COLS);
        brows_eff = eff_size(blk_rows, DEF_MAX_BLOCK);
        bcols_eff = eff_size(blk_cols, DEF_MAX_BLOCK);
        last_col = col_pos >= cols_eff - 1;
        last_row = row_pos >= rows_eff - 1;
        col_done = last_col || (col_in_blk >= bcols_eff - 1);
        row_done = last_row || (row_in_blk >= brows_eff - 1);

        if (row_in_blk == '0 && col_in_blk == '0) begin
            stripe_sums[out_col] = SUM_W'(px);
        end else begin
            stripe_sums[out_col] = stripe_sums[out_col] + SUM_W'(px);
        end

        if (col_done && row_done) begin
            count = (int'(row_in_blk) + 1) * (int'(col_in_blk) + 1);
            res.mean = MEAN_W'(stripe_sums[out_col] / count);
            res.row_end = last_col;
            res.frame_end = last_col && last_row;
            mean_queue.push_back(res);
        end

        if (last_col) begin
            col_pos = '0;
            col_in_blk = '0;
            out_col = '0;
            if (last_row) begin
                row_pos = '0;
                row_in_blk = '0;
            end else begin
                row_pos = row_pos + 1'b1;
                row_in_blk = row_done ? '0 : row_in_blk + 1'b1;
            end
        end else begin
            col_pos = col_pos + 1'b1;
            if (col_done) begin
                col_in_blk = '0;
                out_col = out_col + 1'b1;
            end else begin
                col_in_blk = col_in_blk + 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        block_mean_t got;
        block_mean_t want;
        if (!aresetn) begin
            img_rows = RST_IMAGE_ROWS;
            img_cols = RST_IMAGE_COLS;
            blk_rows = RST_BLOCK_ROWS;
            blk_cols = RST_BLOCK_COLS;
            row_pos = '0;
            col_pos = '0;
            row_in_blk = '0;
            col_in_blk = '0;
            out_col = '0;
            mean_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_ROWS: img_rows = cfg_data;
                    REG_IMAGE_COLS: img_cols = cfg_data;
                    REG_BLOCK_ROWS: blk_rows = cfg_data[BLK_CFG_W-1:0];
                    REG_BLOCK_COLS: blk_cols = cfg_data[BLK_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                accumulate_pixel(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got = '{mean: m_tdata, row_end: m_tlast, frame_end: m_tuser};
                if (mean_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("checker: unexpected mean %0d row_end %0b frame_end %0b",
                                 got.mean, got.row_end, got.frame_end);
                    end
                end else begin
                    want = mean_queue.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"checker: mean mismatch, expected %0d/%0b/%0b, ",
                                      "got %0d/%0b/%0b (mean/row_end/frame_end)"},
                                     want.mean, want.row_end, want.frame_end,
                                     got.mean, got.row_end, got.frame_end);
                        end
                    end
                end
            end
        end
        expected_left = mean_queue.size();
    end

endmodule

// ===== dv/tb.sv =====
// Top of the box-average downscaler testbench: clock, reset, pixel and register stimulus,
// output back-pressure and the final verdict. Depends on bavg_pkg, bavg_mean_checker and
// box_average_downscaler_top.
`timescale 1ns / 100ps

module tb;
    import bavg_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PIXELS = 660;

    typedef enum logic [1:0] {
        PIX_RANDOM,
        PIX_ZERO,
        PIX_FULL
    } pix_fill_t;

    typedef struct packed {
        logic                 wr;
        logic [IMG_CFG_W-1:0] rows;
        logic [IMG_CFG_W-1:0] cols;
        logic [BLK_CFG_W-1:0] brows;
        logic [BLK_CFG_W-1:0] bcols;
        logic [7:0]           n;
        pix_fill_t            fill;
    } phase_t;

    // Each entry starts on a block boundary left behind by the entry before it.
    localparam phase_t PLAN [8] = '{
        '{1'b0, 11'd100, 11'd100, 7'd1, 7'd1, 8'd2, PIX_RANDOM},
        '{1'b1, 11'd1, 11'd0, 7'd1, 7'd1, 8'd1, PIX_FULL},
        '{1'b1, 11'd2, 11'd3, 7'd127, 7'd127, 8'd6, PIX_FULL},
        '{1'b1, 11'd3, 11'd3, 7'd2, 7'd2, 8'd9, PIX_RANDOM},
        '{1'b1, 11'd2047, 11'd1, 7'd2, 7'd0, 8'd4, PIX_ZERO},
        '{1'b1, 11'd2, 11'd1, 7'd1, 7'd1, 8'd1, PIX_RANDOM},
        '{1'b1, 11'd1, 11'd2047, 7'd1, 7'd3, 8'd3, PIX_RANDOM},
        '{1'b1, 11'd0, 11'd0, 7'd0, 7'd1, 8'd1, PIX_FULL}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [MEAN_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index = REG_IMAGE_ROWS;
    logic [IMG_CFG_W-1:0] cfg_data = '0;

    int   mismatches;
    int   expected_left;
    logic at_frame_start;
    logic at_stripe_start;
    logic at_block_start;

    logic                 calm = 1'b1;
    logic                 squeeze = 1'b0;
    int                   pixels_sent = 0;
    int                   means_seen = 0;
    int                   settings = 0;
    logic [IMG_CFG_W-1:0] cur_rows = RST_IMAGE_ROWS;
    logic [IMG_CFG_W-1:0] cur_cols = RST_IMAGE_COLS;

    box_average_downscaler_top u_dut (.*);

    bavg_mean_checker u_checker (
        .*,
        .mismatches(mismatches),
        .expected_left(expected_left),
        .at_frame_start(at_frame_start),
        .at_stripe_start(at_stripe_start),
        .at_block_start(at_block_start)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            means_seen++;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off once the stimulus asks for it.
    initial begin
        int   stall_left;
        logic held;
        stall_left = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (squeeze && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                          : $urandom_range(10, 50);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [IMG_CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            return '0;
        end
        if (r < 85) begin
            return IMG_CFG_W'($urandom_range(1, 10));
        end
        return IMG_CFG_W'($urandom_range(11, 20));
    endfunction

    function automatic logic [BLK_CFG_W-1:0] pick_block();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 80) begin
            return BLK_CFG_W'($urandom_range(1, 4));
        end
        if (r < 92) begin
            return BLK_CFG_W'($urandom_range(5, 12));
        end
        return BLK_CFG_W'($urandom_range(13, 127));
    endfunction

    task automatic wait_idle();
        do @(posedge aclk); while (expected_left != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [IMG_CFG_W-1:0] rows, input logic [IMG_CFG_W-1:0] cols,
                                input logic [BLK_CFG_W-1:0] brows,
                                input logic [BLK_CFG_W-1:0] bcols);
        cfg_reg_t idx;
        idx = idx.first();
        repeat (idx.num()) begin
            case (idx)
                REG_IMAGE_ROWS: cfg_data <= rows;
                REG_IMAGE_COLS: cfg_data <= cols;
                REG_BLOCK_ROWS: cfg_data <= IMG_CFG_W'(brows);
                default: cfg_data <= IMG_CFG_W'(bcols);
            endcase
            cfg_index <= idx;
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
        cur_rows = rows;
        cur_cols = cols;
        settings++;
    endtask

    task automatic send_pixels(input int n, input pix_fill_t fill);
        logic [PIX_W-1:0] px;
        int               gap;
        int               r;
        repeat (n) begin
            case (fill)
                PIX_ZERO: px = '0;
                PIX_FULL: px = '1;
                default: px = PIX_W'($urandom_range(0, 255));
            endcase
            r = $urandom_range(0, 99);
            gap = (calm || r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= px;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            pixels_sent++;
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        logic [IMG_CFG_W-1:0] rows;
        logic [IMG_CFG_W-1:0] cols;
        logic [BLK_CFG_W-1:0] brows;
        logic [BLK_CFG_W-1:0] bcols;
        pix_fill_t            fill;
        int                   random_start;
        int                   n;
        int                   r;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (PLAN[i]) begin
            wait_idle();
            calm = (i % 2 == 0);
            if (PLAN[i].wr) begin
                write_config(PLAN[i].rows, PLAN[i].cols, PLAN[i].brows, PLAN[i].bcols);
            end
            send_pixels(PLAN[i].n, PLAN[i].fill);
        end

        // One-pixel blocks produce a mean per pixel, so the hold-off backs up the input.
        wait_idle();
        calm = 1'b1;
        write_config(11'd8, 11'd8, 7'd1, 7'd1);
        squeeze <= 1'b1;
        send_pixels(64, PIX_RANDOM);

        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            wait_idle();
            if (at_block_start && $urandom_range(0, 99) < 85) begin
                rows = pick_dim();
                cols = pick_dim();
                brows = pick_block();
                bcols = pick_block();
                // Off a stripe boundary only one-row blocks keep every sum well defined.
                if (!at_stripe_start) begin
                    brows = BLK_CFG_W'($urandom_range(0, 1));
                end
                write_config(rows, cols, brows, bcols);
            end
            if (at_frame_start) begin
                n = (cur_rows == '0 ? 1 : int'(cur_rows)) * (cur_cols == '0 ? 1 : int'(cur_cols));
                if ($urandom_range(0, 4) == 0) begin
                    n = $urandom_range(1, n);
                end
            end else begin
                n = $urandom_range(1, 30);
            end
            if (n > RANDOM_PIXELS - (pixels_sent - random_start)) begin
                n = RANDOM_PIXELS - (pixels_sent - random_start);
            end
            r = $urandom_range(0, 99);
            fill = (r < 10) ? PIX_FULL : (r < 20) ? PIX_ZERO : PIX_RANDOM;
            calm = ($urandom_range(0, 3) == 0);
            send_pixels(n, fill);
        end

        calm = 1'b0;
        wait_idle();
        $display("tb: %0d pixels in, %0d block means out, %0d register settings",
                 pixels_sent, means_seen, settings);
        $display("tb: covered zero and oversized sizes, clipped edge blocks, %s",
                 "mid-frame size changes and a long output hold-off");
        if (mismatches == 0 && expected_left == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
